// ===== rtl/core/acr_pkg.sv =====
`timescale 1ns / 1ps
package acr_pkg;

  localparam int DEF_CACHE_ENTRIES = 16;
  localparam int MAC_BYTES = 6;
  localparam logic [47:0] MAC_MASK = (MAC_BYTES >= 6) ? 48'hffff_ffff_ffff :
                                     48'((64'd1 << (8 * MAC_BYTES)) - 64'd1);
  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  // configuration register indexes
  localparam logic [2:0] REG_MY_IP = 3'd0;
  localparam logic [2:0] REG_MY_MAC = 3'd1;
  localparam logic [2:0] REG_SUBNET_MASK = 3'd2;
  localparam logic [2:0] REG_BROADCAST_IP = 3'd3;
  localparam logic [2:0] REG_GATEWAY_IP = 3'd4;
  localparam logic [2:0] REG_GATEWAY_VALID = 3'd5;
  localparam logic [2:0] REG_ALIVE_TICKS = 3'd6;
  localparam logic [2:0] REG_GRACE_TICKS = 3'd7;

  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ARP = 2'd1;
  localparam logic [1:0] CMD_RARP = 2'd2;
  localparam logic [1:0] CMD_RESOLVE = 2'd3;

  localparam logic [2:0] OPC_ARP_REQ = 3'd0;
  localparam logic [2:0] OPC_ARP_REPLY = 3'd1;
  localparam logic [2:0] OPC_RARP_REPLY = 3'd3;

  localparam logic [2:0] STS_HANDLED = 3'd0;
  localparam logic [2:0] STS_REJECTED = 3'd1;
  localparam logic [2:0] STS_HIT = 3'd2;
  localparam logic [2:0] STS_PENDING = 3'd3;
  localparam logic [2:0] STS_FAIL = 3'd4;
  localparam logic [2:0] STS_IMPOSTER = 3'd5;

  localparam logic [1:0] ENT_NEED = 2'd0;
  localparam logic [1:0] ENT_FOUND = 2'd1;
  localparam logic [1:0] ENT_FIXED = 2'd2;
  localparam logic [1:0] ENT_IMPOSTER = 2'd3;

  typedef enum logic [2:0] {
    OP_TICK, OP_REJECT, OP_PLAIN, OP_ARP_REPLY, OP_RARP, OP_RESOLVE
  } op_t;

  typedef enum logic [1:0] {
    B_IDLE, B_DISPATCH, B_SCAN, B_DECIDE
  } bstate_t;

  typedef struct packed {
    logic [31:0] my_ip;
    logic [47:0] my_mac;
    logic [31:0] subnet_mask;
    logic [31:0] broadcast_ip;
    logic [31:0] gateway_ip;
    logic        gateway_valid;
    logic [15:0] alive_ticks;
    logic [15:0] grace_ticks;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] look_ip;
    logic [47:0] mac;
    logic        tx_reply;
    logic [31:0] reply_ip;
    logic [47:0] reply_mac;
    logic        assign_valid;
    logic [31:0] assign_ip;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] resolved_mac;
    logic        tx_valid;
    logic        tx_is_reply;
    logic [31:0] tx_target_ip;
    logic [47:0] tx_target_mac;
    logic        imposter_seen;
    logic        assigned_valid;
    logic [31:0] assigned_ip;
  } res_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] hw;
    logic [1:0]  state;
    logic [31:0] expiry;
  } entry_t;

  function automatic logic is_stale(logic [31:0] now, logic [31:0] expiry,
                                    logic [15:0] grace);
    logic [31:0] diff;
    diff = now - (expiry + {16'd0, grace});
    return ~diff[31];
  endfunction

endpackage

// ===== rtl/core/acr_front.sv =====
`timescale 1ns / 1ps
module acr_front (
  input  logic [1:0]         cmd,
  input  logic [2:0]         opcode,
  input  logic               proto_is_ip,
  input  logic [31:0]        src_ip,
  input  logic [47:0]        src_mac,
  input  logic [31:0]        dst_ip,
  input  logic [47:0]        dst_mac,
  input  logic [31:0]        query_ip,
  input  acr_pkg::cfg_t      cfg,
  output acr_pkg::item_t     item
);
  import acr_pkg::*;

  always_comb begin
    item = '0;
    item.op = OP_TICK;
    item.look_ip = src_ip;
    item.mac = src_mac & MAC_MASK;
    item.reply_ip = src_ip;
    item.reply_mac = src_mac & MAC_MASK;
    item.assign_ip = dst_ip;
    unique case (cmd)
      CMD_TICK: item.op = OP_TICK;
      CMD_ARP: begin
        if (!proto_is_ip) begin
          item.op = OP_REJECT;
        end else begin
          item.op = (opcode == OPC_ARP_REPLY) ? OP_ARP_REPLY : OP_PLAIN;
          // answer requests aimed at us, even while unassigned
          item.tx_reply = (opcode == OPC_ARP_REQ) && (dst_ip == cfg.my_ip);
        end
      end
      CMD_RARP: begin
        if (!proto_is_ip) begin
          item.op = OP_REJECT;
        end else begin
          item.op = OP_RARP;
          item.assign_valid = (cfg.my_ip == '0) && (opcode == OPC_RARP_REPLY) &&
                              ((dst_mac & MAC_MASK) == (cfg.my_mac & MAC_MASK));
        end
      end
      CMD_RESOLVE: begin
        item.op = OP_RESOLVE;
        item.look_ip = query_ip;
      end
      default: item.op = OP_TICK;
    endcase
  end

endmodule

// ===== rtl/core/acr_queue.sv =====
`timescale 1ns / 1ps
module acr_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  acr_pkg::item_t push_data,
  input  logic           pop,
  output acr_pkg::item_t pop_data,
  output logic           full,
  output logic           empty
);
  import acr_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      if (push && !pop) count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

// ===== rtl/core/acr_back.sv =====
`timescale 1ns / 1ps
module acr_back #(
  parameter int CACHE_ENTRIES = acr_pkg::DEF_CACHE_ENTRIES
) (
  input  logic           clk,
  input  logic           rst,
  input  acr_pkg::cfg_t  cfg,
  input  logic           q_empty,
  input  acr_pkg::item_t q_data,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output acr_pkg::res_t  res
);
  import acr_pkg::*;

  localparam int IdxW = $clog2(CACHE_ENTRIES);
  localparam int CntW = $clog2(CACHE_ENTRIES + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(CACHE_ENTRIES);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(CACHE_ENTRIES - 1);

  bstate_t state, state_next;

  entry_t               mem [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid;
  entry_t               rd_e;
  logic                 rd_v;
  entry_t               scan_e;
  logic [IdxW-1:0]      rd_addr;

  item_t           cur;
  logic [31:0]     cur_ip;
  logic            allow_gw;
  logic [31:0]     now_ticks;
  logic [IdxW-1:0] victim;
  logic [CntW-1:0] cnt;
  logic            hit_found;
  logic [IdxW-1:0] hit_idx;
  entry_t          hit_e;
  logic            free_found;
  logic [IdxW-1:0] free_idx;

  logic            res_ready;
  logic            load_res;
  res_t            res_next;
  logic            we;
  logic [IdxW-1:0] wa;
  entry_t          wd;
  logic            tick_inc;
  logic            victim_we;
  logic [IdxW-1:0] victim_next;
  logic            restart;
  logic            start_scan;

  logic            unresolvable;
  logic            hit_ok;
  logic            off_net;
  logic [IdxW-1:0] victim_inc;

  assign res_ready = !out_valid || !out_stall;
  assign rd_addr = (cnt < CntLast) ? cnt[IdxW-1:0] : '0;
  assign unresolvable = (cur_ip == '0) || (cur_ip == ALL_ONES) ||
                        (cur_ip == cfg.broadcast_ip);
  assign hit_ok = hit_found && ((hit_e.state == ENT_FOUND) || (hit_e.state == ENT_FIXED));
  assign off_net = allow_gw && (((cur_ip ^ cfg.my_ip) & cfg.subnet_mask) != '0);
  assign victim_inc = (victim == IdxLast) ? '0 : victim + IdxW'(1);
  assign scan_e = rd_v ? rd_e : '0;

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_e <= mem[rd_addr];
    rd_v <= valid[rd_addr];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_DISPATCH;
      B_DISPATCH: begin
        priority if (start_scan) state_next = B_SCAN;
        else if (load_res) state_next = B_IDLE;
      end
      B_SCAN: if (cnt == CntLast) state_next = B_DECIDE;
      B_DECIDE: begin
        priority if (restart) state_next = B_DISPATCH;
        else if (load_res) state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    load_res = 1'b0;
    res_next = '0;
    we = 1'b0;
    wa = hit_idx;
    wd = hit_e;
    tick_inc = 1'b0;
    victim_we = 1'b0;
    victim_next = victim_inc;
    restart = 1'b0;
    start_scan = 1'b0;
    res_next.status = STS_HANDLED;
    unique case (state)
      B_IDLE: q_pop = !q_empty;
      B_DISPATCH: begin
        unique case (cur.op)
          OP_ARP_REPLY, OP_RARP: start_scan = 1'b1;
          OP_RESOLVE: begin
            if (!unresolvable) begin
              start_scan = 1'b1;
            end else if (res_ready) begin
              load_res = 1'b1;
              res_next.status = STS_FAIL;
            end
          end
          OP_TICK: begin
            load_res = res_ready;
            tick_inc = res_ready;
          end
          OP_REJECT: begin
            load_res = res_ready;
            res_next.status = STS_REJECTED;
          end
          OP_PLAIN: begin
            load_res = res_ready;
            res_next.tx_valid = cur.tx_reply;
            res_next.tx_is_reply = cur.tx_reply;
            res_next.tx_target_ip = cur.tx_reply ? cur.reply_ip : '0;
            res_next.tx_target_mac = cur.tx_reply ? cur.reply_mac : '0;
          end
          default: load_res = 1'b0;
        endcase
      end
      B_SCAN: q_pop = 1'b0;
      B_DECIDE: begin
        if (res_ready) begin
          unique case (cur.op)
            OP_ARP_REPLY, OP_RARP: begin
              load_res = 1'b1;
              if (hit_found) begin
                we = 1'b1;
                wd.expiry = now_ticks + {16'd0, cfg.alive_ticks};
                wd.hw = cur.mac;
                wd.state = ENT_FOUND;
                if (cur.op == OP_ARP_REPLY && cur_ip == cfg.my_ip) begin
                  wd.state = ENT_IMPOSTER;
                  res_next.status = STS_IMPOSTER;
                  res_next.imposter_seen = 1'b1;
                end
              end
              if (cur.op == OP_RARP) begin
                res_next.assigned_valid = cur.assign_valid;
                res_next.assigned_ip = cur.assign_valid ? cur.assign_ip : '0;
              end
            end
            OP_RESOLVE: begin
              if (hit_ok && !is_stale(now_ticks, hit_e.expiry, cfg.grace_ticks)) begin
                load_res = 1'b1;
                res_next.status = STS_HIT;
                res_next.resolved_mac = hit_e.hw;
              end else begin
                // expired entry falls back to need-address
                if (hit_ok) begin
                  we = 1'b1;
                  wd.state = ENT_NEED;
                end
                if (off_net) begin
                  if (cfg.gateway_valid) begin
                    restart = 1'b1;
                  end else begin
                    load_res = 1'b1;
                    res_next.status = STS_FAIL;
                  end
                end else begin
                  load_res = 1'b1;
                  res_next.status = STS_PENDING;
                  res_next.tx_valid = 1'b1;
                  res_next.tx_target_ip = cur_ip;
                  if (!hit_found) begin
                    we = 1'b1;
                    wa = free_found ? free_idx : victim_inc;
                    victim_we = !free_found;
                    wd.ip = cur_ip;
                    wd.hw = '0;
                    wd.state = ENT_NEED;
                    wd.expiry = now_ticks;
                  end
                end
              end
            end
            default: load_res = 1'b1;
          endcase
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      valid <= '0;
      now_ticks <= '0;
      victim <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we) valid[wa] <= 1'b1;
      if (tick_inc) now_ticks <= now_ticks + 32'd1;
      if (victim_we) victim <= victim_next;
      if (load_res) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) res <= res_next;
    if (q_pop) begin
      cur <= q_data;
      cur_ip <= q_data.look_ip;
      allow_gw <= 1'b1;
    end
    if (restart) begin
      cur_ip <= cfg.gateway_ip;
      allow_gw <= 1'b0;
    end
    if (start_scan) begin
      cnt <= '0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else if (state == B_SCAN) begin
      cnt <= cnt + CntW'(1);
      if (cnt != '0) begin
        // record first match and first reusable slot
        if (!hit_found && cur_ip != '0 && scan_e.ip == cur_ip) begin
          hit_found <= 1'b1;
          hit_idx <= IdxW'(cnt - CntW'(1));
          hit_e <= scan_e;
        end
        if (!free_found && (scan_e.ip == '0 ||
            is_stale(now_ticks, scan_e.expiry, cfg.grace_ticks))) begin
          free_found <= 1'b1;
          free_idx <= IdxW'(cnt - CntW'(1));
        end
      end
    end
  end

endmodule

// ===== rtl/core/arp_cache_responder.sv =====
`timescale 1ns / 1ps
// ARP cache and responder. Requests enter through a classifier and a two-entry
// queue; a tick, a rejected packet or an ARP request is answered without
// touching the entry store, while an ARP reply, a RARP packet or a resolve query
// for a resolvable address walks the entry store once, and a query resolved
// through the gateway walks it twice. A stalled result holds the back end.
// The store has a valid bit per entry cleared at reset, so no clearing pass is
// needed. Configuration is written by index through cfg_valid/cfg_ready.
module arp_cache_responder #(
  parameter int CACHE_ENTRIES = acr_pkg::DEF_CACHE_ENTRIES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cmd,
  input  logic [2:0]  opcode,
  input  logic        proto_is_ip,
  input  logic [31:0] src_ip,
  input  logic [47:0] src_mac,
  input  logic [31:0] dst_ip,
  input  logic [47:0] dst_mac,
  input  logic [31:0] query_ip,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [47:0] resolved_mac,
  output logic        tx_valid,
  output logic        tx_is_reply,
  output logic [31:0] tx_target_ip,
  output logic [47:0] tx_target_mac,
  output logic        imposter_seen,
  output logic        assigned_valid,
  output logic [31:0] assigned_ip
);
  import acr_pkg::*;

  cfg_t  cfg;
  item_t item;
  item_t q_data;
  res_t  res;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall = q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_ip <= '0;
      cfg.my_mac <= '0;
      cfg.subnet_mask <= '0;
      cfg.broadcast_ip <= ALL_ONES;
      cfg.gateway_ip <= '0;
      cfg.gateway_valid <= 1'b0;
      cfg.alive_ticks <= 16'd300;
      cfg.grace_ticks <= 16'd100;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MY_IP: cfg.my_ip <= cfg_data[31:0];
        REG_MY_MAC: cfg.my_mac <= cfg_data;
        REG_SUBNET_MASK: cfg.subnet_mask <= cfg_data[31:0];
        REG_BROADCAST_IP: cfg.broadcast_ip <= cfg_data[31:0];
        REG_GATEWAY_IP: cfg.gateway_ip <= cfg_data[31:0];
        REG_GATEWAY_VALID: cfg.gateway_valid <= cfg_data[0];
        REG_ALIVE_TICKS: cfg.alive_ticks <= cfg_data[15:0];
        REG_GRACE_TICKS: cfg.grace_ticks <= cfg_data[15:0];
        default: cfg.my_ip <= cfg.my_ip;
      endcase
    end
  end

  acr_front u_front (
    .cmd(cmd), .opcode(opcode), .proto_is_ip(proto_is_ip),
    .src_ip(src_ip), .src_mac(src_mac),
    .dst_ip(dst_ip), .dst_mac(dst_mac),
    .query_ip(query_ip), .cfg(cfg), .item(item)
  );

  acr_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_valid && !in_stall), .push_data(item),
    .pop(q_pop), .pop_data(q_data),
    .full(q_full), .empty(q_empty)
  );

  acr_back #(.CACHE_ENTRIES(CACHE_ENTRIES)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .q_empty(q_empty), .q_data(q_data), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .res(res)
  );

  assign status = res.status;
  assign resolved_mac = res.resolved_mac;
  assign tx_valid = res.tx_valid;
  assign tx_is_reply = res.tx_is_reply;
  assign tx_target_ip = res.tx_target_ip;
  assign tx_target_mac = res.tx_target_mac;
  assign imposter_seen = res.imposter_seen;
  assign assigned_valid = res.assigned_valid;
  assign assigned_ip = res.assigned_ip;

endmodule

// ===== test/arp_cache_responder_tb.sv =====
`timescale 1ns / 1ps
module arp_cache_responder_tb;
  import acr_pkg::*;

  localparam int ENTRIES = DEF_CACHE_ENTRIES;
  localparam int CYCLE_LIMIT = 800000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [2:0]  opcode;
    logic        is_ip;
    logic [31:0] s_ip;
    logic [47:0] s_mac;
    logic [31:0] t_ip;
    logic [47:0] t_mac;
    logic [31:0] q_ip;
  } arp_req_t;

  typedef struct packed {
    arp_req_t r;
    logic     typed;
    res_t     want;
  } dir_row_t;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [2:0] cfg_index;
  logic [47:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] cmd;
  logic [2:0] opcode;
  logic proto_is_ip;
  logic [31:0] src_ip, dst_ip, query_ip;
  logic [47:0] src_mac, dst_mac;
  logic out_valid, out_stall;
  logic [2:0] status;
  logic [47:0] resolved_mac, tx_target_mac;
  logic tx_valid, tx_is_reply, imposter_seen, assigned_valid;
  logic [31:0] tx_target_ip, assigned_ip;

  arp_cache_responder DUT (.*);

  // shadow cache
  logic [31:0] sh_ip[ENTRIES];
  logic [47:0] sh_hw[ENTRIES];
  logic [1:0]  sh_st[ENTRIES];
  logic [31:0] sh_exp[ENTRIES];
  logic [31:0] now_t;
  logic [3:0]  victim;
  cfg_t        cur;

  res_t replies_due[$];
  dir_row_t rows[$];
  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  function automatic logic aged_out(int i);
    logic [31:0] d;
    d = now_t - (sh_exp[i] + {16'd0, cur.grace_ticks});
    return !d[31];
  endfunction

  function automatic int find_ip(logic [31:0] ip);
    int k;
    k = -1;
    for (int i = 0; i < ENTRIES; i++)
      if (k < 0 && ip != 0 && sh_ip[i] == ip) k = i;
    return k;
  endfunction

  function automatic void refresh(int i, logic [47:0] mac);
    sh_exp[i] = now_t + {16'd0, cur.alive_ticks};
    sh_hw[i] = mac & MAC_MASK;
    sh_st[i] = ENT_FOUND;
  endfunction

  function automatic res_t predict_response(arp_req_t r);
    res_t o;
    int i;
    logic [31:0] ina;
    logic gw_ok, done;
    o = '0;
    case (r.cmd)
      CMD_TICK: now_t = now_t + 1;
      CMD_ARP: begin
        if (!r.is_ip) begin
          o.status = STS_REJECTED;
        end else begin
          if (r.opcode == OPC_ARP_REPLY) begin
            i = find_ip(r.s_ip);
            if (i >= 0) begin
              refresh(i, r.s_mac);
              if (r.s_ip == cur.my_ip) begin
                sh_st[i] = ENT_IMPOSTER;
                o.status = STS_IMPOSTER;
                o.imposter_seen = 1;
              end
            end
          end
          if (r.opcode == OPC_ARP_REQ && r.t_ip == cur.my_ip) begin
            o.tx_valid = 1;
            o.tx_is_reply = 1;
            o.tx_target_ip = r.s_ip;
            o.tx_target_mac = r.s_mac & MAC_MASK;
          end
        end
      end
      CMD_RARP: begin
        if (!r.is_ip) begin
          o.status = STS_REJECTED;
        end else begin
          i = find_ip(r.s_ip);
          if (i >= 0) refresh(i, r.s_mac);
          if (cur.my_ip == 0 && r.opcode == OPC_RARP_REPLY &&
              (r.t_mac & MAC_MASK) == (cur.my_mac & MAC_MASK)) begin
            o.assigned_valid = 1;
            o.assigned_ip = r.t_ip;
          end
        end
      end
      default: begin
        // at most two passes: the address itself, then the gateway
        ina = r.q_ip;
        gw_ok = 1;
        done = 0;
        while (!done) begin
          done = 1;
          if (ina == 0 || ina == ALL_ONES || ina == cur.broadcast_ip) begin
            o.status = STS_FAIL;
          end else begin
            i = find_ip(ina);
            if (i >= 0 && (sh_st[i] == ENT_FOUND || sh_st[i] == ENT_FIXED) &&
                !aged_out(i)) begin
              o.status = STS_HIT;
              o.resolved_mac = sh_hw[i];
            end else begin
              if (i >= 0 && (sh_st[i] == ENT_FOUND || sh_st[i] == ENT_FIXED))
                sh_st[i] = ENT_NEED;
              if (gw_ok && ((ina ^ cur.my_ip) & cur.subnet_mask) != 0) begin
                if (cur.gateway_valid) begin
                  ina = cur.gateway_ip;
                  gw_ok = 0;
                  done = 0;
                end else begin
                  o.status = STS_FAIL;
                end
              end else begin
                if (i < 0) begin
                  for (int j = 0; j < ENTRIES; j++)
                    if (i < 0 && (sh_ip[j] == 0 || aged_out(j))) i = j;
                  if (i < 0) begin
                    victim = victim + 1;
                    i = victim;
                  end
                  sh_st[i] = ENT_NEED;
                  sh_hw[i] = 0;
                  sh_exp[i] = now_t;
                  sh_ip[i] = ina;
                end
                o.status = STS_PENDING;
                o.tx_valid = 1;
                o.tx_target_ip = ina;
              end
            end
          end
        end
      end
    endcase
    return o;
  endfunction

  function automatic arp_req_t mk(logic [1:0] c, logic [2:0] op, logic ip,
                                  logic [31:0] sip, logic [47:0] smac,
                                  logic [31:0] tip, logic [47:0] tmac,
                                  logic [31:0] qip);
    return '{c, op, ip, sip, smac, tip, tmac, qip};
  endfunction

  function automatic res_t sts_only(logic [2:0] s);
    res_t o;
    o = '0;
    o.status = s;
    return o;
  endfunction

  task automatic send(arp_req_t r, logic typed, res_t want);
    res_t p;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1;
    {cmd, opcode, proto_is_ip, src_ip, src_mac, dst_ip, dst_mac,
     query_ip} <= r;
    do @(posedge clk); while (in_stall);
    p = predict_response(r);
    replies_due.push_back(typed ? want : p);
  endtask

  // hold the input idle until every reply is back, then load all registers
  task automatic load_cfg(cfg_t c);
    logic [47:0] vals[8];
    in_valid <= 0;
    while (replies_due.size() != 0) @(posedge clk);
    vals = '{48'(c.my_ip), c.my_mac, 48'(c.subnet_mask), 48'(c.broadcast_ip),
             48'(c.gateway_ip), 48'(c.gateway_valid), 48'(c.alive_ticks),
             48'(c.grace_ticks)};
    for (int k = REG_MY_IP; k <= REG_GRACE_TICKS; k++) begin
      cfg_valid <= 1;
      cfg_index <= 3'(k);
      cfg_data <= vals[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 0;
    cur = c;
  endtask

  function automatic logic [31:0] pick_ip();
    logic [31:0] net;
    net = cur.my_ip & cur.subnet_mask;
    case ($urandom_range(0, 11))
      0: return cur.my_ip;
      1: return cur.gateway_ip;
      2: return 32'd0;
      3: return cur.broadcast_ip;
      4: return ALL_ONES;
      5: return $urandom;
      6: return $urandom_range(1, 30) ^ 32'h5500_0000;
      default: return net | ($urandom_range(1, 24) & ~cur.subnet_mask);
    endcase
  endfunction

  function automatic logic [47:0] pick_mac();
    case ($urandom_range(0, 5))
      0: return cur.my_mac;
      1: return 48'hffff_ffff_ffff;
      2: return 48'd0;
      default: return {$urandom, $urandom} & MAC_MASK;
    endcase
  endfunction

  function automatic arp_req_t rand_req();
    arp_req_t r;
    r.cmd = 2'($urandom_range(0, 3));
    r.opcode = ($urandom_range(0, 3) == 0) ? 3'($urandom) : 3'($urandom_range(0, 3));
    r.is_ip = $urandom_range(0, 9) != 0;
    r.s_ip = pick_ip();
    r.s_mac = pick_mac();
    r.t_ip = pick_ip();
    r.t_mac = pick_mac();
    r.q_ip = pick_ip();
    return r;
  endfunction

  task automatic run_random(int n);
    arp_req_t r;
    logic [31:0] ip;
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(0, 1)) begin
        // resolve, answer it, then ask again
        ip = pick_ip();
        r = rand_req();
        r.cmd = CMD_RESOLVE;
        r.q_ip = ip;
        send(r, 0, '0);
        r = rand_req();
        r.cmd = CMD_ARP;
        r.opcode = OPC_ARP_REPLY;
        r.is_ip = 1;
        r.s_ip = ($urandom_range(0, 3) == 0) ? cur.gateway_ip : ip;
        send(r, 0, '0);
        r.cmd = CMD_RESOLVE;
        r.q_ip = ip;
        send(r, 0, '0);
        cnt += 3;
      end else begin
        send(rand_req(), 0, '0);
        cnt++;
      end
    end
  endtask

  task automatic chk(string name, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    cycles <= cycles + 1;
    if (cycles % 101 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall <= 0;
      1: out_stall <= $urandom_range(0, 3) == 0;
      default: out_stall <= $urandom_range(0, 9) < 7;
    endcase
    if (!rst && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected reply: expected none, got status %0d", $realtime,
                 status);
        errors++;
      end else begin
        e = replies_due.pop_front();
        chk("status", e.status, status);
        chk("resolved_mac", e.resolved_mac, resolved_mac);
        chk("tx_valid", e.tx_valid, tx_valid);
        chk("tx_is_reply", e.tx_is_reply, tx_is_reply);
        chk("tx_target_ip", e.tx_target_ip, tx_target_ip);
        chk("tx_target_mac", e.tx_target_mac, tx_target_mac);
        chk("imposter_seen", e.imposter_seen, imposter_seen);
        chk("assigned_valid", e.assigned_valid, assigned_valid);
        chk("assigned_ip", e.assigned_ip, assigned_ip);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    rst = 1;
    cfg_valid = 0;
    cfg_index = 0;
    cfg_data = 0;
    in_valid = 0;
    {cmd, opcode, proto_is_ip, src_ip, src_mac, dst_ip, dst_mac,
     query_ip} = '0;
    out_stall = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      sh_ip[i] = 0; sh_hw[i] = 0; sh_st[i] = ENT_NEED; sh_exp[i] = 0;
    end
    now_t = 0;
    victim = 0;
    cur = '{32'd0, 48'd0, 32'd0, ALL_ONES, 32'd0, 1'b0, 16'd300, 16'd100};
    repeat (3) @(posedge clk);
    rst <= 0;

    // reset settings: unassigned address, no gateway
    rows.push_back('{mk(CMD_TICK, 0, 1, 0, 0, 0, 0, 0), 1, sts_only(STS_HANDLED)});
    rows.push_back('{mk(CMD_ARP, OPC_ARP_REQ, 0, 1, 2, 0, 3, 0), 1,
                     sts_only(STS_REJECTED)});
    rows.push_back('{mk(CMD_RARP, OPC_RARP_REPLY, 0, 1, 2, 3, 0, 0), 1,
                     sts_only(STS_REJECTED)});
    rows.push_back('{mk(CMD_ARP, OPC_ARP_REQ, 1, 32'h0102_0304, 48'ha1a2_a3a4_a5a6,
                        0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_RARP, OPC_RARP_REPLY, 1, 0, 0, 32'h0a00_0005, 0, 0),
                     0, '0});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 0), 1, sts_only(STS_FAIL)});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, ALL_ONES), 1,
                     sts_only(STS_FAIL)});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0a00_0009), 0, '0});
    rows.push_back('{mk(CMD_ARP, OPC_ARP_REPLY, 1, 32'h0a00_0009, 48'hffff_ffff_ffff,
                        0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0a00_0009), 0, '0});
    rows.push_back('{mk(CMD_ARP, 3'd7, 1, 32'h0a00_0009, 1, ALL_ONES, 1, 0), 0, '0});
    rows.push_back('{mk(CMD_RARP, 3'd2, 1, 32'h0a00_0009, 7, 0, 0, 0), 0, '0});
    foreach (rows[k]) send(rows[k].r, rows[k].typed, rows[k].want);
    rows.delete();

    c = '{32'h0a00_0005, 48'h0200_0000_0005, 32'hffff_ff00, 32'h0a00_00ff,
          32'h0a00_0001, 1'b1, 16'd5, 16'd2};
    load_cfg(c);
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0808_0808), 0, '0});
    rows.push_back('{mk(CMD_ARP, OPC_ARP_REPLY, 1, 32'h0a00_0001, 48'h0000_1111_2222,
                        0, 0, 0), 0, '0});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0808_0808), 0, '0});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0a00_0005), 0, '0});
    rows.push_back('{mk(CMD_ARP, OPC_ARP_REPLY, 1, 32'h0a00_0005, 48'h0bad, 0, 0, 0),
                     0, '0});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0a00_0005), 0, '0});
    rows.push_back('{mk(CMD_ARP, OPC_ARP_REQ, 1, 32'h0a00_0020, 48'h0c0c, 32'h0a00_0005,
                        0, 0), 0, '0});
    rows.push_back('{mk(CMD_RARP, OPC_RARP_REPLY, 1, 0, 0, 32'h0a00_0077,
                        48'h0200_0000_0005, 0), 0, '0});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0a00_00ff), 1,
                     sts_only(STS_FAIL)});
    for (int t = 0; t < 9; t++) rows.push_back('{mk(CMD_TICK, 0, 0, 0, 0, 0, 0, 0),
                                                 0, '0});
    rows.push_back('{mk(CMD_RESOLVE, 0, 1, 0, 0, 0, 0, 32'h0808_0808), 0, '0});
    foreach (rows[k]) send(rows[k].r, rows[k].typed, rows[k].want);

    for (int ph = 0; ph < 6; ph++) begin
      c.my_ip = $urandom;
      c.my_mac = {$urandom, $urandom};
      c.subnet_mask = 32'hffff_ff00;
      c.broadcast_ip = c.my_ip | 32'hff;
      c.gateway_ip = (c.my_ip & 32'hffff_ff00) | 32'd1;
      c.gateway_valid = 1;
      c.alive_ticks = $urandom_range(2, 40);
      c.grace_ticks = $urandom_range(0, 10);
      case (ph)
        0: begin c.alive_ticks = 1; c.grace_ticks = 0; end
        1: begin
          c.alive_ticks = 16'hffff; c.grace_ticks = 16'hffff;
          c.subnet_mask = ALL_ONES; c.gateway_valid = 0;
        end
        2: begin c.my_ip = 0; c.subnet_mask = 0; c.my_mac = 48'hffff_ffff_ffff; end
        3: begin c.subnet_mask = 32'hffff_0000; c.broadcast_ip = 0; end
        4: begin c.gateway_ip = 0; c.my_mac = 0; end
        default: c.gateway_ip = $urandom;
      endcase
      load_cfg(c);
      run_random(310);
    end

    in_valid <= 0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
